### rtl/lcdm_pkg.sv
// shared constants, types and register codes of the lens distortion coordinate map
package lcdm_pkg;

  localparam int COORD_W    = 16;
  localparam int COEF_W     = 16;
  localparam int SIZE_W     = 12;
  localparam int PIX_W      = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // fraction bits of coordinates and of coefficients
  localparam int COORD_FRAC_BITS = 14;
  localparam int COEF_FRAC_BITS  = 12;

  // source image limit, clamp target is MAX_DIM-1
  localparam int MAX_DIM = 4096;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1          = 4'd0,
    CFG_K2          = 4'd1,
    CFG_P1          = 4'd2,
    CFG_P2          = 4'd3,
    CFG_HALF_WIDTH  = 4'd4,
    CFG_HALF_HEIGHT = 4'd5,
    CFG_CENTER_COL  = 4'd6,
    CFG_CENTER_ROW  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] p1;
    logic signed [COEF_W-1:0] p2;
    logic [SIZE_W-1:0]        half_width;
    logic [SIZE_W-1:0]        half_height;
    logic [SIZE_W-1:0]        center_col;
    logic [SIZE_W-1:0]        center_row;
  } cfg_t;

  // radial factor and tangential offsets handed from the polynomial front end
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [27:0]        radial;
    logic signed [24:0]        tan_x;
    logic signed [24:0]        tan_y;
  } warp_t;

endpackage

### rtl/lcdm_if.sv
// channel interfaces: normalised coordinate in, source pixel out
interface lcdm_coord_if;
  import lcdm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] norm_x;
  logic signed [COORD_W-1:0] norm_y;

  modport source (output valid, output norm_x, output norm_y, input ready);
  modport sink   (input valid, input norm_x, input norm_y, output ready);
endinterface

interface lcdm_pix_if;
  import lcdm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_col;
  logic [PIX_W-1:0] src_row;
  logic             in_range;

  modport source (output valid, output src_col, output src_row, output in_range, input ready);
  modport sink   (input valid, input src_col, input src_row, input in_range, output ready);
endinterface

### rtl/lens_distortion_coordinate_map_top.sv
// top level of the lens distortion coordinate map
//
//  channel   dir  handshake      payload
//  coord_i   in   valid/ready    norm_x, norm_y (signed q2.14)
//  pix_o     out  valid/ready    src_col, src_row, in_range
//  cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_wdata_i
//
//  one beat per clock sustained while pix_o takes every result
//  there are nine register stages: five in the polynomial front end, four in the back end
//  each stage holds only when it is full and the one after it holds, so bubbles squeeze out
//  and input is still taken while a finished result waits on pix_o, as long as a stage is empty
//  reset clears the stage valid bits and loads the register defaults; no clearing pass
module lens_distortion_coordinate_map_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcdm_coord_if.sink                      coord_i,
  lcdm_pix_if.source                      pix_o,
  input  logic                            cfg_we_i,
  input  logic [lcdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcdm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lcdm_pkg::*;

  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(MAX_DIM - 1);

  cfg_t  cfg;
  warp_t warp;
  logic  warp_valid;
  logic  place_ready;
  logic  coord_ready;

  // coefficient and geometry registers, kept static by the user while beats are in flight
  lcdm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // r2, r4, radial factor and tangential terms
  lcdm_warp u_warp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (coord_i.valid),
    .in_ready_o  (coord_ready),
    .norm_x_i    (coord_i.norm_x),
    .norm_y_i    (coord_i.norm_y),
    .cfg_i       (cfg),
    .out_valid_o (warp_valid),
    .out_ready_i (place_ready),
    .out_o       (warp)
  );

  // distorted position scaled to source pixels, then clamped
  lcdm_place u_place (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (warp_valid),
    .in_ready_o  (place_ready),
    .in_i        (warp),
    .cfg_i       (cfg),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .src_col_o   (pix_o.src_col),
    .src_row_o   (pix_o.src_row),
    .in_range_o  (pix_o.in_range)
  );

  assign coord_i.ready = coord_ready;

  // input only backs up when every stage is full behind a stalled output
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coord_ready |-> (pix_o.valid && !pix_o.ready))
    else $error("input stalled while the pipeline has room");

  // an out-of-range result sits on an image edge
  a_clamp_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && !pix_o.in_range) |->
      (pix_o.src_col == '0 || pix_o.src_col == PIX_MAX ||
       pix_o.src_row == '0 || pix_o.src_row == PIX_MAX))
    else $error("clamped result away from image edge");

  // a half width write lands in the register on the next edge
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CFG_HALF_WIDTH) |=>
      (cfg.half_width == $past(cfg_wdata_i[SIZE_W-1:0])))
    else $error("half width write lost");

endmodule

### rtl/lcdm_cfg.sv
// configuration register file
module lcdm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lcdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcdm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lcdm_pkg::cfg_t                  cfg_o
);
  import lcdm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_K1:          cfg_d.k1          = $signed(cfg_wdata_i[COEF_W-1:0]);
        CFG_K2:          cfg_d.k2          = $signed(cfg_wdata_i[COEF_W-1:0]);
        CFG_P1:          cfg_d.p1          = $signed(cfg_wdata_i[COEF_W-1:0]);
        CFG_P2:          cfg_d.p2          = $signed(cfg_wdata_i[COEF_W-1:0]);
        CFG_HALF_WIDTH:  cfg_d.half_width  = cfg_wdata_i[SIZE_W-1:0];
        CFG_HALF_HEIGHT: cfg_d.half_height = cfg_wdata_i[SIZE_W-1:0];
        CFG_CENTER_COL:  cfg_d.center_col  = cfg_wdata_i[SIZE_W-1:0];
        CFG_CENTER_ROW:  cfg_d.center_row  = cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k1          <= '0;
      cfg_q.k2          <= '0;
      cfg_q.p1          <= '0;
      cfg_q.p2          <= '0;
      cfg_q.half_width  <= SIZE_RST;
      cfg_q.half_height <= SIZE_RST;
      cfg_q.center_col  <= SIZE_RST;
      cfg_q.center_row  <= SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/lcdm_warp.sv
// polynomial front end: squares, radial factor and tangential offsets, five stages
module lcdm_warp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lcdm_pkg::COORD_W-1:0] norm_x_i,
  input  logic signed [lcdm_pkg::COORD_W-1:0] norm_y_i,
  input  lcdm_pkg::cfg_t                      cfg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lcdm_pkg::warp_t                     out_o
);
  import lcdm_pkg::*;

  localparam int NSTG = 5;
  localparam int TF   = COORD_FRAC_BITS + COEF_FRAC_BITS;
  localparam logic signed [38:0] RND_K = 39'((1 << COEF_FRAC_BITS) - 1);
  localparam logic signed [50:0] RND_T = 51'((1 << TF) - 1);
  localparam logic signed [27:0] ONE_F = 28'(1 << COORD_FRAC_BITS);

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_in;

  // stage a: products of the coordinates
  logic signed [COORD_W-1:0] x_a_q, y_a_q;
  logic signed [31:0]        xx_a_q, yy_a_q, xy_a_q;
  // stage b
  logic signed [COORD_W-1:0] x_b_q, y_b_q;
  logic signed [18:0]        r2_b_q;
  logic signed [33:0]        sx_b_q, sy_b_q;
  logic signed [47:0]        p1xy_b_q, p2xy_b_q;
  logic signed [32:0]        sum_b;
  // stage c
  logic signed [COORD_W-1:0] x_c_q, y_c_q;
  logic signed [21:0]        r4_c_q;
  logic signed [34:0]        k1r2_c_q;
  logic signed [49:0]        p2sx_c_q, p1sy_c_q;
  logic signed [47:0]        p1xy_c_q, p2xy_c_q;
  logic signed [37:0]        r4p_c;
  // stage d
  logic signed [COORD_W-1:0] x_d_q, y_d_q;
  logic signed [34:0]        k1r2_d_q;
  logic signed [37:0]        k2r4_d_q;
  logic signed [50:0]        tanx_d_q, tany_d_q;
  // stage e
  warp_t                     e_q;
  logic signed [38:0]        rsum_e, rsum_r_e;
  logic signed [50:0]        tanx_r_e, tany_r_e;

  // a stage moves on when it is empty or its successor moves on
  always_comb begin
    en[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_a_q  <= norm_x_i;
      y_a_q  <= norm_y_i;
      xx_a_q <= 32'(norm_x_i) * 32'(norm_x_i);
      yy_a_q <= 32'(norm_y_i) * 32'(norm_y_i);
      xy_a_q <= 32'(norm_x_i) * 32'(norm_y_i);
    end
  end

  assign sum_b = 33'(xx_a_q) + 33'(yy_a_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x_b_q    <= x_a_q;
      y_b_q    <= y_a_q;
      r2_b_q   <= 19'(sum_b >>> COORD_FRAC_BITS);
      sx_b_q   <= (34'(xx_a_q) <<< 1) + 34'(xx_a_q) + 34'(yy_a_q);
      sy_b_q   <= 34'(xx_a_q) + (34'(yy_a_q) <<< 1) + 34'(yy_a_q);
      p1xy_b_q <= 48'($signed(cfg_i.p1)) * 48'(xy_a_q);
      p2xy_b_q <= 48'($signed(cfg_i.p2)) * 48'(xy_a_q);
    end
  end

  assign r4p_c = 38'(r2_b_q) * 38'(r2_b_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x_c_q    <= x_b_q;
      y_c_q    <= y_b_q;
      r4_c_q   <= 22'(r4p_c >>> COORD_FRAC_BITS);
      k1r2_c_q <= 35'($signed(cfg_i.k1)) * 35'(r2_b_q);
      p2sx_c_q <= 50'($signed(cfg_i.p2)) * 50'(sx_b_q);
      p1sy_c_q <= 50'($signed(cfg_i.p1)) * 50'(sy_b_q);
      p1xy_c_q <= p1xy_b_q;
      p2xy_c_q <= p2xy_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      x_d_q    <= x_c_q;
      y_d_q    <= y_c_q;
      k1r2_d_q <= k1r2_c_q;
      k2r4_d_q <= 38'($signed(cfg_i.k2)) * 38'(r4_c_q);
      tanx_d_q <= (51'(p1xy_c_q) <<< 1) + 51'(p2sx_c_q);
      tany_d_q <= 51'(p1sy_c_q) + (51'(p2xy_c_q) <<< 1);
    end
  end

  // divisions by powers of two round toward zero
  assign rsum_e   = 39'(k1r2_d_q) + 39'(k2r4_d_q);
  assign rsum_r_e = rsum_e + (rsum_e[38] ? RND_K : 39'sd0);
  assign tanx_r_e = tanx_d_q + (tanx_d_q[50] ? RND_T : 51'sd0);
  assign tany_r_e = tany_d_q + (tany_d_q[50] ? RND_T : 51'sd0);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_q.x      <= x_d_q;
      e_q.y      <= y_d_q;
      e_q.radial <= 28'(rsum_r_e >>> COEF_FRAC_BITS) + ONE_F;
      e_q.tan_x  <= 25'(tanx_r_e >>> TF);
      e_q.tan_y  <= 25'(tany_r_e >>> TF);
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_o       = e_q;

endmodule

### rtl/lcdm_place.sv
// back end: distorted position, scaling to pixels, clamp and output register
module lcdm_place (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lcdm_pkg::warp_t              in_i,
  input  lcdm_pkg::cfg_t               cfg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lcdm_pkg::PIX_W-1:0]   src_col_o,
  output logic [lcdm_pkg::PIX_W-1:0]   src_row_o,
  output logic                         in_range_o
);
  import lcdm_pkg::*;

  localparam int NSTG = 4;
  localparam logic signed [43:0] RND_M = 44'((1 << COORD_FRAC_BITS) - 1);
  localparam logic signed [44:0] RND_S = 45'((1 << COORD_FRAC_BITS) - 1);
  localparam logic signed [30:0] V_MAX = 31'(MAX_DIM - 1);

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_in;

  // stage f
  logic signed [43:0] mx_f_q, my_f_q;
  logic signed [24:0] tqx_f_q, tqy_f_q;
  // stage g
  logic signed [30:0] dx_g_q, dy_g_q;
  logic signed [43:0] mx_r, my_r;
  // stage h
  logic signed [43:0] px_h_q, py_h_q;
  // output register
  logic [PIX_W-1:0]   col_q, row_q;
  logic               inr_q;
  logic [PIX_W:0]     col_res, row_res;

  // add the centre, truncate toward zero, clamp; msb flags in range
  function automatic logic [PIX_W:0] to_pixel(logic signed [43:0] p,
                                              logic [SIZE_W-1:0] center);
    logic signed [44:0] s;
    logic signed [44:0] s_r;
    logic signed [30:0] v;
    logic [PIX_W:0]     res;
    s   = 45'(p) + 45'($signed({1'b0, center, {COORD_FRAC_BITS{1'b0}}}));
    s_r = s + (s[44] ? RND_S : 45'sd0);
    v   = 31'(s_r >>> COORD_FRAC_BITS);
    if (v < 31'sd0) begin
      res = '0;
    end else if (v > V_MAX) begin
      res = {1'b0, V_MAX[PIX_W-1:0]};
    end else begin
      res = {1'b1, v[PIX_W-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    en[NSTG] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mx_f_q  <= 44'($signed(in_i.x)) * 44'($signed(in_i.radial));
      my_f_q  <= 44'($signed(in_i.y)) * 44'($signed(in_i.radial));
      tqx_f_q <= in_i.tan_x;
      tqy_f_q <= in_i.tan_y;
    end
  end

  assign mx_r = mx_f_q + (mx_f_q[43] ? RND_M : 44'sd0);
  assign my_r = my_f_q + (my_f_q[43] ? RND_M : 44'sd0);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx_g_q <= 31'(mx_r >>> COORD_FRAC_BITS) + 31'(tqx_f_q);
      dy_g_q <= 31'(my_r >>> COORD_FRAC_BITS) + 31'(tqy_f_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      px_h_q <= 44'(dx_g_q) * 44'($signed({1'b0, cfg_i.half_width}));
      py_h_q <= 44'(dy_g_q) * 44'($signed({1'b0, cfg_i.half_height}));
    end
  end

  assign col_res = to_pixel(px_h_q, cfg_i.center_col);
  assign row_res = to_pixel(py_h_q, cfg_i.center_row);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      col_q <= col_res[PIX_W-1:0];
      row_q <= row_res[PIX_W-1:0];
      inr_q <= col_res[PIX_W] & row_res[PIX_W];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign src_col_o   = col_q;
  assign src_row_o   = row_q;
  assign in_range_o  = inr_q;

endmodule
